>>> design/mlbs_pkg.sv
// Shared types and constants of the multistyle lightmap bilinear sampler.
package mlbs_pkg;

  localparam int unsigned CFG_IW    = 3;
  localparam int unsigned CFG_DW    = 10;
  localparam int unsigned TEXEL_W   = 24;
  localparam int unsigned TADDR_W   = 12;
  localparam int unsigned WEIGHT_W  = 17;
  localparam int unsigned PROD_W    = 25;
  localparam int unsigned Q8_W      = 16;
  localparam int unsigned SCALED_W  = 18;
  localparam int unsigned COLOR_W   = 20;
  localparam int unsigned NUM_SLOTS = 4;
  localparam int unsigned NUM_CHAN  = 3;
  localparam int unsigned NUM_CORN  = 4;
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned RES_DEPTH = 8;

  localparam logic [5:0] MAP_DIM_RESET     = 6'd2;
  localparam logic [2:0] STYLE_COUNT_RESET = 3'd0;
  localparam logic [9:0] STYLE_SCALE_RESET = 10'd256;

  typedef enum logic [CFG_IW-1:0] {
    REG_MAP_WIDTH    = 3'd0,
    REG_MAP_HEIGHT   = 3'd1,
    REG_STYLE_COUNT  = 3'd2,
    REG_STYLE_SCALE0 = 3'd3,
    REG_STYLE_SCALE1 = 3'd4,
    REG_STYLE_SCALE2 = 3'd5,
    REG_STYLE_SCALE3 = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef struct packed {
    logic       op;
    logic [1:0] style_slot;
    logic [9:0] texel_index;
    logic [7:0] texel_red;
    logic [7:0] texel_green;
    logic [7:0] texel_blue;
    logic [4:0] coord_s;
    logic [4:0] coord_t;
    logic [7:0] frac_s;
    logic [7:0] frac_t;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color_red;
    logic [COLOR_W-1:0] color_green;
    logic [COLOR_W-1:0] color_blue;
    logic               range_error;
  } out_item_t;

  // corner order: 00, 10, 01, 11
  typedef struct packed {
    op_e                                kind;
    logic                               err;
    logic [1:0]                         slot;
    logic [TADDR_W-1:0]                 addr00;
    logic [TADDR_W-1:0]                 addr01;
    logic [TEXEL_W-1:0]                 texel;
    logic [NUM_CORN-1:0][WEIGHT_W-1:0]  weight;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic first;
    logic last;
    logic err;
  } beat_t;

endpackage

>>> design/multistyle_lightmap_bilinear_sampler.sv
// Top level of the multistyle lightmap bilinear sampler: configuration registers and queues.
//
// Texel loads and sample points enter through a queue-style push port and are
// classified by the front end, then wait in a four-entry command queue for the
// back end. A load is written into the texel store; a sample is issued once
// per active style (at least one), each issue making the four texel reads a
// style needs: the texel store is held as two copies with two read ports each.
// A sample result reaches the result queue after its last style has passed the
// blend, scale and sum pipeline; up to eight results may wait there without
// holding up the back end. The texel store needs no clearing after reset;
// reading a texel that was never loaded gives an undefined colour. Configuration
// writes are always accepted and must only be made while no transaction is in flight.
module multistyle_lightmap_bilinear_sampler import mlbs_pkg::*; #(
  parameter int unsigned MAX_TEXELS = 1024,
  parameter int unsigned MAX_STYLES = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  in_item_t          item_i,
  output logic              full_o,
  input  logic              pop_i,
  output out_item_t         result_o,
  output logic              empty_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  logic [5:0]                        map_width_q, map_height_q;
  logic [2:0]                        style_count_q;
  logic [NUM_SLOTS-1:0][CFG_DW-1:0]  style_scale_q;

  logic       cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t       cmd_in, cmd_out;
  logic       res_push, res_full, res_free;
  out_item_t  res_in;

  assign cfg_ready_o = 1'b1;
  assign full_o      = cmd_full;
  assign res_free    = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q   <= MAP_DIM_RESET;
      map_height_q  <= MAP_DIM_RESET;
      style_count_q <= STYLE_COUNT_RESET;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        style_scale_q[i] <= STYLE_SCALE_RESET;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MAP_WIDTH:    map_width_q      <= cfg_data_i[5:0];
        REG_MAP_HEIGHT:   map_height_q     <= cfg_data_i[5:0];
        REG_STYLE_COUNT:  style_count_q    <= cfg_data_i[2:0];
        REG_STYLE_SCALE0: style_scale_q[0] <= cfg_data_i;
        REG_STYLE_SCALE1: style_scale_q[1] <= cfg_data_i;
        REG_STYLE_SCALE2: style_scale_q[2] <= cfg_data_i;
        REG_STYLE_SCALE3: style_scale_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mlbs_front #(
    .MAX_TEXELS (MAX_TEXELS),
    .MAX_STYLES (MAX_STYLES)
  ) u_front (
    .item_i       (item_i),
    .push_i       (push_i),
    .cmd_full_i   (cmd_full),
    .map_width_i  (map_width_q),
    .map_height_i (map_height_q),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in)
  );

  mlbs_fifo #(
    .T     (cmd_t),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  mlbs_back #(
    .MAX_TEXELS (MAX_TEXELS),
    .MAX_STYLES (MAX_STYLES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_out),
    .cmd_empty_i   (cmd_empty),
    .cmd_pop_o     (cmd_pop),
    .style_count_i (style_count_q),
    .style_scale_i (style_scale_q),
    .res_free_i    (res_free),
    .res_push_o    (res_push),
    .res_o         (res_in)
  );

  mlbs_fifo #(
    .T     (out_item_t),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .data_o  (result_o),
    .empty_o (empty_o)
  );

  // space is reserved by the back end before issue, so the result queue never refuses a push
  logic unused_res_full;
  assign unused_res_full = res_full;

endmodule

>>> design/mlbs_fifo.sv
// Small register queue used between front and back and for finished results.
module mlbs_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T               entry_q [DEPTH];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = entry_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= data_i;
    end
  end

endmodule

>>> design/mlbs_front.sv
// Front end: classifies incoming transactions, checks ranges, forms addresses and weights.
module mlbs_front import mlbs_pkg::*; #(
  parameter int unsigned MAX_TEXELS = 1024,
  parameter int unsigned MAX_STYLES = 4
) (
  input  in_item_t   item_i,
  input  logic       push_i,
  input  logic       cmd_full_i,
  input  logic [5:0] map_width_i,
  input  logic [5:0] map_height_i,
  output logic       cmd_push_o,
  output cmd_t       cmd_o
);

  logic                accept, load_ok;
  logic [10:0]         row_base;
  logic [13:0]         a00, a01, a11;
  logic [WEIGHT_W-1:0] ia, ib, fa, fb;

  always_comb begin
    accept   = push_i && !cmd_full_i;
    load_ok  = ({1'b0, item_i.style_slot} < 3'(MAX_STYLES)) &&
               (13'(item_i.texel_index) < 13'(MAX_TEXELS));
    row_base = 11'(item_i.coord_t) * 11'(map_width_i);
    a00      = 14'(row_base) + 14'(item_i.coord_s);
    a01      = a00 + 14'(map_width_i);
    a11      = a01 + 14'd1;
    fa       = WEIGHT_W'(item_i.frac_s);
    fb       = WEIGHT_W'(item_i.frac_t);
    ia       = WEIGHT_W'(256) - fa;
    ib       = WEIGHT_W'(256) - fb;

    cmd_o.kind   = op_e'(item_i.op);
    cmd_o.slot   = item_i.style_slot;
    cmd_o.texel  = {item_i.texel_red, item_i.texel_green, item_i.texel_blue};
    cmd_o.err    = ((7'(item_i.coord_s) + 7'd1) >= 7'(map_width_i)) ||
                   ((7'(item_i.coord_t) + 7'd1) >= 7'(map_height_i)) ||
                   (a11 >= 14'(MAX_TEXELS));
    cmd_o.addr01 = a01[TADDR_W-1:0];
    cmd_o.weight[0] = ia * ib;
    cmd_o.weight[1] = fa * ib;
    cmd_o.weight[2] = ia * fb;
    cmd_o.weight[3] = fa * fb;
    if (item_i.op == OP_SAMPLE) begin
      cmd_o.addr00 = a00[TADDR_W-1:0];
      cmd_push_o   = accept;
    end else begin
      cmd_o.addr00 = TADDR_W'(item_i.texel_index);
      cmd_push_o   = accept && load_ok;
    end
  end

endmodule

>>> design/mlbs_back.sv
// Back end: texel memories, per-style sequencing and the blend, scale and sum pipeline.
module mlbs_back import mlbs_pkg::*; #(
  parameter int unsigned MAX_TEXELS = 1024,
  parameter int unsigned MAX_STYLES = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cmd_t                               cmd_i,
  input  logic                               cmd_empty_i,
  output logic                               cmd_pop_o,
  input  logic [2:0]                         style_count_i,
  input  logic [NUM_SLOTS-1:0][CFG_DW-1:0]   style_scale_i,
  input  logic                               res_free_i,
  output logic                               res_push_o,
  output out_item_t                          res_o
);

  localparam int unsigned DEPTH  = MAX_STYLES * MAX_TEXELS;
  localparam int unsigned MEM_AW = $clog2(DEPTH);
  localparam int unsigned RES_CW = $clog2(RES_DEPTH + 1);

  logic [TEXEL_W-1:0] mem_a [DEPTH];
  logic [TEXEL_W-1:0] mem_b [DEPTH];

  logic [1:0]          style_q, style_d;
  logic [RES_CW-1:0]   resv_q, resv_d;
  logic [2:0]          n_styles, nbeats;
  logic                is_load, is_smp, active, last, room, issue;
  logic [MEM_AW-1:0]   base, wbase, ra00, ra10, ra01, ra11, wa;
  beat_t               beat;

  logic                                 s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  beat_t                                s1_beat_q, s2_beat_q, s3_beat_q, s4_beat_q;
  logic [CFG_DW-1:0]                    s1_scale_q, s2_scale_q, s3_scale_q;
  logic [NUM_CORN-1:0][WEIGHT_W-1:0]    s1_w_q;
  logic [NUM_CORN-1:0][TEXEL_W-1:0]     rd_q;
  logic [NUM_CHAN-1:0][NUM_CORN-1:0][PROD_W-1:0] p_q, p_d;
  logic [NUM_CHAN-1:0][Q8_W-1:0]        q8_q, q8_d;
  logic [NUM_CHAN-1:0][SCALED_W-1:0]    sc_q, sc_d;
  logic [NUM_CHAN-1:0][COLOR_W-1:0]     acc_q, acc_d;
  logic [PROD_W:0]                      blend [NUM_CHAN];
  logic [25:0]                          prod_sc [NUM_CHAN];

  always_comb begin
    n_styles = (style_count_i > 3'(MAX_STYLES)) ? 3'(MAX_STYLES) : style_count_i;
    is_load  = !cmd_empty_i && (cmd_i.kind == OP_LOAD);
    is_smp   = !cmd_empty_i && (cmd_i.kind == OP_SAMPLE);
    active   = !cmd_i.err && (n_styles != 3'd0);
    nbeats   = active ? n_styles : 3'd1;
    last     = (({1'b0, style_q} + 3'd1) == nbeats);
    room     = (resv_q < RES_CW'(RES_DEPTH));
    issue    = is_smp && (!last || room);
    cmd_pop_o = is_load || (issue && last);

    base  = MEM_AW'(32'(style_q) * MAX_TEXELS);
    wbase = MEM_AW'(32'(cmd_i.slot) * MAX_TEXELS);
    ra00  = base + MEM_AW'(cmd_i.addr00);
    ra10  = ra00 + MEM_AW'(1);
    ra01  = base + MEM_AW'(cmd_i.addr01);
    ra11  = ra01 + MEM_AW'(1);
    wa    = wbase + MEM_AW'(cmd_i.addr00);

    beat.active = active;
    beat.first  = (style_q == 2'd0);
    beat.last   = last;
    beat.err    = cmd_i.err;

    style_d = style_q;
    if (issue) begin
      style_d = last ? 2'd0 : style_q + 2'd1;
    end
    resv_d = resv_q + RES_CW'(issue && last) - RES_CW'(res_free_i);
  end

  always_ff @(posedge clk_i) begin
    if (is_load) begin
      mem_a[wa] <= cmd_i.texel;
      mem_b[wa] <= cmd_i.texel;
    end
    if (issue) begin
      rd_q[0] <= mem_a[ra00];
      rd_q[1] <= mem_a[ra10];
      rd_q[2] <= mem_b[ra01];
      rd_q[3] <= mem_b[ra11];
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      for (int k = 0; k < NUM_CORN; k++) begin
        p_d[c][k] = PROD_W'(s1_w_q[k]) *
                    PROD_W'(rd_q[k][TEXEL_W-1-8*c -: 8]);
      end
      blend[c] = (PROD_W+1)'(p_q[c][0]) + (PROD_W+1)'(p_q[c][1]) +
                 (PROD_W+1)'(p_q[c][2]) + (PROD_W+1)'(p_q[c][3]);
      q8_d[c]    = blend[c][Q8_W+7:8];
      prod_sc[c] = 26'(q8_q[c]) * 26'(s3_scale_q);
      sc_d[c]    = prod_sc[c][25:8];
      acc_d[c]   = (s4_beat_q.first ? '0 : acc_q[c]) +
                   (s4_beat_q.active ? COLOR_W'(sc_q[c]) : '0);
    end
    res_push_o        = s4_valid_q && s4_beat_q.last;
    res_o.color_red   = acc_d[0];
    res_o.color_green = acc_d[1];
    res_o.color_blue  = acc_d[2];
    res_o.range_error = s4_beat_q.err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      style_q    <= '0;
      resv_q     <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      style_q    <= style_d;
      resv_q     <= resv_d;
      s1_valid_q <= issue;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_beat_q  <= beat;
      s1_w_q     <= cmd_i.weight;
      s1_scale_q <= style_scale_i[style_q];
    end
    if (s1_valid_q) begin
      s2_beat_q  <= s1_beat_q;
      s2_scale_q <= s1_scale_q;
      p_q        <= p_d;
    end
    if (s2_valid_q) begin
      s3_beat_q  <= s2_beat_q;
      s3_scale_q <= s2_scale_q;
      q8_q       <= q8_d;
    end
    if (s3_valid_q) begin
      s4_beat_q <= s3_beat_q;
      sc_q      <= sc_d;
    end
    if (s4_valid_q) begin
      acc_q <= acc_d;
    end
  end

endmodule

>>> test/mlbs_checker.sv
// Checker for the multistyle lightmap bilinear sampler: predicts each sample's colour and compares.
module mlbs_checker import mlbs_pkg::*; #(
  parameter int unsigned MAX_TEXELS = 1024,
  parameter int unsigned MAX_STYLES = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  in_item_t          item_i,
  input  logic              full_i,
  input  logic              pop_i,
  input  out_item_t         result_i,
  input  logic              empty_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       outstanding_o
);

  logic [5:0]         map_width_q;
  logic [5:0]         map_height_q;
  logic [2:0]         style_count_q;
  logic [CFG_DW-1:0]  style_scale_q [NUM_SLOTS];
  logic [TEXEL_W-1:0] texel_mem [MAX_STYLES*MAX_TEXELS];
  out_item_t          colours_due [$];
  int unsigned        mismatches;
  int unsigned        pending;

  assign fail_count_o  = mismatches + pending;
  assign outstanding_o = pending;

  function automatic out_item_t light_sample(in_item_t item);
    out_item_t                 res;
    int unsigned               s, t, w, h, n, base;
    int unsigned               addr [NUM_CORN];
    int                        p, c, k;
    logic [8:0]                inv_s, inv_t;
    logic [WEIGHT_W-1:0]       wgt [NUM_CORN];
    logic [23:0]               blend;
    logic [Q8_W+CFG_DW-1:0]    prod;
    logic [COLOR_W-1:0]        acc [NUM_CHAN];
    logic [TEXEL_W-1:0]        texel;
    res = '0;
    s = item.coord_s;
    t = item.coord_t;
    w = map_width_q;
    h = map_height_q;
    if (s + 1 >= w || t + 1 >= h || (t + 1) * w + s + 1 >= MAX_TEXELS) begin
      res.range_error = 1'b1;
      return res;
    end
    inv_s = 9'd256 - item.frac_s;
    inv_t = 9'd256 - item.frac_t;
    wgt[0] = inv_s * inv_t;
    wgt[1] = item.frac_s * inv_t;
    wgt[2] = inv_s * item.frac_t;
    wgt[3] = item.frac_s * item.frac_t;
    addr[0] = t * w + s;
    addr[1] = addr[0] + 1;
    addr[2] = addr[0] + w;
    addr[3] = addr[2] + 1;
    n = (style_count_q > MAX_STYLES) ? MAX_STYLES : style_count_q;
    for (c = 0; c < NUM_CHAN; c++) begin
      acc[c] = '0;
    end
    for (p = 0; p < n; p++) begin
      base = p * MAX_TEXELS;
      for (c = 0; c < NUM_CHAN; c++) begin
        blend = '0;
        for (k = 0; k < NUM_CORN; k++) begin
          texel = texel_mem[base + addr[k]];
          blend += wgt[k] * texel[(NUM_CHAN-1-c)*8 +: 8];
        end
        prod = blend[23:8] * style_scale_q[p];
        acc[c] += prod[Q8_W+CFG_DW-1:8];
      end
    end
    res.color_red   = acc[0];
    res.color_green = acc[1];
    res.color_blue  = acc[2];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_item_t want;
    if (!rst_ni) begin
      map_width_q   = MAP_DIM_RESET;
      map_height_q  = MAP_DIM_RESET;
      style_count_q = STYLE_COUNT_RESET;
      foreach (style_scale_q[i]) style_scale_q[i] = STYLE_SCALE_RESET;
      foreach (texel_mem[i]) texel_mem[i] = '0;
      colours_due.delete();
      mismatches = 0;
      pending    = 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (colours_due.size() == 0) begin
          $error("result with no sample waiting: %p", result_i);
          mismatches++;
        end else begin
          want = colours_due.pop_front();
          if (result_i.color_red !== want.color_red) begin
            $error("color_red: expected %0d, got %0d", want.color_red, result_i.color_red);
            mismatches++;
          end
          if (result_i.color_green !== want.color_green) begin
            $error("color_green: expected %0d, got %0d", want.color_green,
                   result_i.color_green);
            mismatches++;
          end
          if (result_i.color_blue !== want.color_blue) begin
            $error("color_blue: expected %0d, got %0d", want.color_blue, result_i.color_blue);
            mismatches++;
          end
          if (result_i.range_error !== want.range_error) begin
            $error("range_error: expected %0d, got %0d", want.range_error,
                   result_i.range_error);
            mismatches++;
          end
        end
      end
      if (push_i && !full_i) begin
        if (item_i.op == OP_SAMPLE) begin
          colours_due.push_back(light_sample(item_i));
        end else if (item_i.style_slot < MAX_STYLES && item_i.texel_index < MAX_TEXELS) begin
          texel_mem[item_i.style_slot * MAX_TEXELS + item_i.texel_index] =
              {item_i.texel_red, item_i.texel_green, item_i.texel_blue};
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MAP_WIDTH:    map_width_q      = cfg_data_i[5:0];
          REG_MAP_HEIGHT:   map_height_q     = cfg_data_i[5:0];
          REG_STYLE_COUNT:  style_count_q    = cfg_data_i[2:0];
          REG_STYLE_SCALE0: style_scale_q[0] = cfg_data_i;
          REG_STYLE_SCALE1: style_scale_q[1] = cfg_data_i;
          REG_STYLE_SCALE2: style_scale_q[2] = cfg_data_i;
          REG_STYLE_SCALE3: style_scale_q[3] = cfg_data_i;
          default: ;
        endcase
      end
      pending = colours_due.size();
    end
  end

endmodule

>>> test/tb_multistyle_lightmap_bilinear_sampler.sv
// Testbench top of the multistyle lightmap bilinear sampler: stimulus, handshakes and verdict.
module tb_multistyle_lightmap_bilinear_sampler;
  import mlbs_pkg::*;

  localparam int unsigned       MAX_TEXELS  = 1024;
  localparam int unsigned       MAX_STYLES  = 4;
  localparam int unsigned       ITEM_TARGET = 1000;
  localparam int unsigned       SETTLE      = 40;
  localparam int unsigned       CYCLE_LIMIT = 400000;
  localparam logic [CFG_IW-1:0] REG_SPARE   = 3'd7;
  localparam int unsigned       GAP_NONE    = 0;
  localparam int unsigned       GAP_FULL    = 1;
  localparam int unsigned       GAP_RARE    = 2;
  localparam int unsigned       ITEM_W      = $bits(in_item_t);

  logic              clk;
  logic              rst_n;
  logic              push;
  in_item_t          item_in;
  logic              full;
  logic              pop;
  out_item_t         result;
  logic              empty;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;
  int unsigned       fail_count;
  int unsigned       outstanding;

  int unsigned map_w;
  int unsigned map_h;
  int unsigned planes;
  bit          loaded [MAX_STYLES][MAX_TEXELS];
  int unsigned items_sent;
  int unsigned push_mode;
  int unsigned pop_mode;
  int unsigned cycle_count;

  multistyle_lightmap_bilinear_sampler #(
    .MAX_TEXELS(MAX_TEXELS),
    .MAX_STYLES(MAX_STYLES)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push_i     (push),
    .item_i     (item_in),
    .full_o     (full),
    .pop_i      (pop),
    .result_o   (result),
    .empty_o    (empty),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  mlbs_checker #(
    .MAX_TEXELS(MAX_TEXELS),
    .MAX_STYLES(MAX_STYLES)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push_i       (push),
    .item_i       (item_in),
    .full_i       (full),
    .pop_i        (pop),
    .result_i     (result),
    .empty_i      (empty),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  function automatic int unsigned draw_gap(int unsigned mode);
    case (mode)
      GAP_NONE: return 0;
      GAP_FULL: return $urandom_range(0, 16);
      default:  return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  function automatic logic [7:0] draw_byte();
    logic [7:0] v;
    v = 8'($urandom);
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return v;
    endcase
  endfunction

  function automatic logic [TEXEL_W-1:0] draw_texel();
    return {draw_byte(), draw_byte(), draw_byte()};
  endfunction

  function automatic int unsigned draw_dim();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1);
      1:       return $urandom_range(33, 63);
      2:       return 32;
      3:       return 2;
      default: return $urandom_range(3, 10);
    endcase
  endfunction

  function automatic logic [CFG_DW-1:0] draw_scale();
    case ($urandom_range(0, 5))
      0:       return 10'd0;
      1:       return 10'd1023;
      2:       return STYLE_SCALE_RESET;
      default: return CFG_DW'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic in_item_t noise_item();
    in_item_t v;
    v = ITEM_W'({$urandom, $urandom});
    return v;
  endfunction

  function automatic bit reads_store(int unsigned s, int unsigned t);
    return s + 1 < map_w && t + 1 < map_h && (t + 1) * map_w + s + 1 < MAX_TEXELS;
  endfunction

  task automatic send(input in_item_t item);
    int unsigned gap;
    gap = draw_gap(push_mode);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    item_in <= item;
    do @(posedge clk); while (full);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic load_texel(input int unsigned slot, input int unsigned idx,
                            input logic [TEXEL_W-1:0] rgb);
    in_item_t v;
    v = noise_item();
    v.op          = OP_LOAD;
    v.style_slot  = 2'(slot);
    v.texel_index = 10'(idx);
    {v.texel_red, v.texel_green, v.texel_blue} = rgb;
    loaded[slot][idx] = 1'b1;
    send(v);
  endtask

  task automatic sample_at(input int unsigned s, input int unsigned t,
                           input logic [7:0] fs, input logic [7:0] ft);
    in_item_t    v;
    int unsigned corner [NUM_CORN];
    if (reads_store(s, t)) begin
      corner[0] = t * map_w + s;
      corner[1] = corner[0] + 1;
      corner[2] = corner[0] + map_w;
      corner[3] = corner[2] + 1;
      for (int p = 0; p < planes; p++) begin
        foreach (corner[k]) begin
          if (!loaded[p][corner[k]]) load_texel(p, corner[k], draw_texel());
        end
      end
    end
    v = noise_item();
    v.op      = OP_SAMPLE;
    v.coord_s = 5'(s);
    v.coord_t = 5'(t);
    v.frac_s  = fs;
    v.frac_t  = ft;
    send(v);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_config(input int unsigned w, input int unsigned h, input int unsigned cnt,
                            input logic [NUM_SLOTS-1:0][CFG_DW-1:0] scales);
    logic [CFG_DW-1:0] junk;
    junk = $urandom_range(0, 1) ? CFG_DW'($urandom) : '0;
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, CFG_DW'($urandom));
    write_reg(REG_MAP_WIDTH, CFG_DW'((junk << 6) | w));
    write_reg(REG_MAP_HEIGHT, CFG_DW'((junk << 6) | h));
    write_reg(REG_STYLE_COUNT, CFG_DW'((junk << 3) | cnt));
    write_reg(REG_STYLE_SCALE0, scales[0]);
    write_reg(REG_STYLE_SCALE1, scales[1]);
    write_reg(REG_STYLE_SCALE2, scales[2]);
    write_reg(REG_STYLE_SCALE3, scales[3]);
    cfg_valid <= 1'b0;
    map_w  = w;
    map_h  = h;
    planes = (cnt > MAX_STYLES) ? MAX_STYLES : cnt;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : result_drain
    int unsigned gap;
    pop = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      gap = draw_gap(pop_mode);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int unsigned                       phase, phase_end, pick, s, t, hi_s, hi_t, lim;
    int unsigned                       w, h, cnt;
    logic [NUM_SLOTS-1:0][CFG_DW-1:0]  scales;
    rst_n      = 1'b0;
    push       = 1'b0;
    item_in    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    push_mode  = GAP_NONE;
    pop_mode   = GAP_FULL;
    items_sent = 0;
    map_w      = 32'(MAP_DIM_RESET);
    map_h      = 32'(MAP_DIM_RESET);
    planes     = 32'(STYLE_COUNT_RESET);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // no styles active straight after reset
    sample_at(0, 0, draw_byte(), draw_byte());
    drain();
    set_config(2, 2, 4, {NUM_SLOTS{10'd1023}});
    for (int p = 0; p < MAX_STYLES; p++) begin
      for (int i = 0; i < 4; i++) begin
        load_texel(p, i, (p == 0) ? {TEXEL_W{1'b1}} : draw_texel());
      end
    end
    sample_at(0, 0, 8'd0, 8'd0);
    sample_at(0, 0, 8'd255, 8'd255);
    sample_at(0, 0, 8'd0, 8'd255);
    sample_at(0, 0, 8'd255, 8'd0);
    sample_at(0, 0, 8'd128, 8'd128);
    sample_at(1, 0, draw_byte(), draw_byte());
    sample_at(0, 1, draw_byte(), draw_byte());
    sample_at(31, 31, 8'd255, 8'd255);
    drain();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      foreach (scales[i]) scales[i] = draw_scale();
      case (phase)
        0:       begin w = 32; h = 32; cnt = 4; end
        1:       begin w = 2;  h = 2;  cnt = 7; end
        2:       begin w = 1;  h = 32; cnt = 3; end
        3:       begin w = 63; h = 63; cnt = 2; end
        4:       begin w = 5;  h = 0;  cnt = 1; end
        default: begin
          w   = draw_dim();
          h   = draw_dim();
          cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
        end
      endcase
      set_config(w, h, cnt, scales);
      push_mode = $urandom_range(GAP_NONE, GAP_RARE);
      pop_mode  = $urandom_range(GAP_NONE, GAP_RARE);
      phase_end = items_sent + $urandom_range(40, 120);
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          lim = map_w * map_h;
          if (lim == 0 || lim > MAX_TEXELS) lim = MAX_TEXELS;
          load_texel($urandom_range(0, MAX_STYLES - 1),
                     $urandom_range(0, 1) ? $urandom_range(0, lim - 1)
                                          : $urandom_range(0, MAX_TEXELS - 1),
                     draw_texel());
        end else if (pick < 27 || map_w < 2 || map_h < 2) begin
          sample_at($urandom_range(0, 31), $urandom_range(0, 31), draw_byte(), draw_byte());
        end else begin
          hi_s = (map_w - 2 > 31) ? 31 : map_w - 2;
          hi_t = (map_h - 2 > 31) ? 31 : map_h - 2;
          if ($urandom_range(0, 1)) begin
            if (hi_s > 3) hi_s = 3;
            if (hi_t > 3) hi_t = 3;
          end
          s = $urandom_range(0, hi_s);
          t = $urandom_range(0, hi_t);
          if (!reads_store(s, t)) begin
            s = 0;
            t = 0;
          end
          sample_at(s, t, draw_byte(), draw_byte());
        end
      end
      drain();
      phase++;
    end

    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

>>> files.f
design/mlbs_pkg.sv
design/mlbs_fifo.sv
design/mlbs_front.sv
design/mlbs_back.sv
design/multistyle_lightmap_bilinear_sampler.sv
test/mlbs_checker.sv
test/tb_multistyle_lightmap_bilinear_sampler.sv
